### rtl/dmpc_pkg.sv
`timescale 1ns / 1ps
package dmpc_pkg;

  localparam int unsigned DMPC_DATA_WIDTH = 32;

  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned DOMAIN_W   = 31;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Q16.16 product realignment and constant division
  localparam int unsigned PROD_SHIFT = 16;
  localparam int unsigned DIGIT_W    = 8;
  localparam int unsigned REM_W      = 10;
  localparam logic [REM_W-1:0] DIV_K_P = 10'd100;
  localparam logic [REM_W-1:0] DIV_K_I = 10'd1000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CONTROL_MODE    = 3'd0,
    REG_PROP_GAIN       = 3'd1,
    REG_INTEG_GAIN      = 3'd2,
    REG_DERIV_GAIN      = 3'd3,
    REG_INTEG_DOMAIN    = 3'd4,
    REG_DERIV_DOMAIN    = 3'd5,
    REG_OUTPUT_LIMITS   = 3'd6,
    REG_INTEGRAL_LIMITS = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    MODE_INCREMENTAL = 1'b0,
    MODE_POSITIONAL  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_PREP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_COMBINE,
    OP_DIV_START,
    OP_FINISH,
    OP_SUM,
    OP_TOTAL,
    OP_CLAMP,
    OP_COMMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_PREP,
    S_TERM,
    S_MUL_LO,
    S_MUL_HI,
    S_COMBINE,
    S_DIV_START,
    S_DIV_WAIT,
    S_FINISH,
    S_SUM,
    S_TOTAL,
    S_CLAMP,
    S_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    term_e  term;
  } dp_cmd_t;

  typedef struct packed {
    logic term_on;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/dmpc_cdiv.sv
`timescale 1ns / 1ps
module dmpc_cdiv import dmpc_pkg::*; #(
  parameter int unsigned DIVIDEND_W = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  sel_thousand_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic                  done_o
);

  localparam int unsigned NSTEP = DIVIDEND_W / DIGIT_W;
  localparam int unsigned CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  logic [DIVIDEND_W-1:0] sr_q, sr_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [REM_W-1:0]      k_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, done_q;
  logic [DIGIT_W-1:0]    qbyte;

  // one quotient byte a cycle, restoring steps on the small remainder
  always_comb begin
    logic [REM_W-1:0] r;
    logic [REM_W:0]   t;
    r     = rem_q;
    qbyte = '0;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      t = {r, sr_q[DIVIDEND_W - DIGIT_W + b]};
      if (t >= {1'b0, k_q}) begin
        t        = t - {1'b0, k_q};
        qbyte[b] = 1'b1;
      end
      r = t[REM_W-1:0];
    end
    rem_d = r;
    sr_d  = {sr_q[DIVIDEND_W-DIGIT_W-1:0], qbyte};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sr_q  <= dividend_i;
      rem_q <= '0;
      k_q   <= sel_thousand_i ? DIV_K_I : DIV_K_P;
    end else if (busy_q) begin
      sr_q  <= sr_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NSTEP - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = sr_q;
  assign done_o     = done_q;

endmodule

### rtl/dmpc_datapath.sv
`timescale 1ns / 1ps
module dmpc_datapath import dmpc_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DMPC_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned VW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
  localparam int unsigned NW = ((VW + PROD_SHIFT + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam logic signed [VW:0] SatMax =
    (VW+1)'((65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1);
  localparam logic signed [VW:0] SatMin = ~SatMax;

  typedef logic signed [VW-1:0] val_t;

  function automatic val_t sat(input logic signed [VW:0] v);
    logic signed [VW:0] r;
    if (v > SatMax) begin
      r = SatMax;
    end else if (v < SatMin) begin
      r = SatMin;
    end else begin
      r = v;
    end
    return val_t'(r[VW-1:0]);
  endfunction

  function automatic val_t add_sat(input val_t a, input val_t b);
    return sat((VW+1)'(a) + (VW+1)'(b));
  endfunction

  function automatic val_t sub_sat(input val_t a, input val_t b);
    return sat((VW+1)'(a) - (VW+1)'(b));
  endfunction

  function automatic val_t clamp(input val_t v, input val_t hi, input val_t lo);
    val_t r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration
  mode_e                     mode_q;
  logic signed [FIELD_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [DOMAIN_W-1:0]       integ_dom_q, deriv_dom_q;
  logic [FIELD_W-1:0]        out_max_q, out_min_q, integ_max_q, integ_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_INCREMENTAL;
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      deriv_gain_q <= '0;
      integ_dom_q  <= '0;
      deriv_dom_q  <= '0;
      out_max_q    <= '0;
      out_min_q    <= '0;
      integ_max_q  <= '0;
      integ_min_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_CONTROL_MODE:    mode_q       <= mode_e'(cfg_data_i[0]);
        REG_PROP_GAIN:       prop_gain_q  <= cfg_data_i[FIELD_W-1:0];
        REG_INTEG_GAIN:      integ_gain_q <= cfg_data_i[FIELD_W-1:0];
        REG_DERIV_GAIN:      deriv_gain_q <= cfg_data_i[FIELD_W-1:0];
        REG_INTEG_DOMAIN:    integ_dom_q  <= cfg_data_i[DOMAIN_W-1:0];
        REG_DERIV_DOMAIN:    deriv_dom_q  <= cfg_data_i[DOMAIN_W-1:0];
        REG_OUTPUT_LIMITS: begin
          out_max_q <= cfg_data_i[2*FIELD_W-1:FIELD_W];
          out_min_q <= cfg_data_i[FIELD_W-1:0];
        end
        REG_INTEGRAL_LIMITS: begin
          integ_max_q <= cfg_data_i[2*FIELD_W-1:FIELD_W];
          integ_min_q <= cfg_data_i[FIELD_W-1:0];
        end
        default: ;
      endcase
    end
  end

  logic inc;
  assign inc = (mode_q == MODE_INCREMENTAL);

  val_t out_max, out_min, integ_max, integ_min;
  assign out_max   = VW'(signed'(out_max_q));
  assign out_min   = VW'(signed'(out_min_q));
  assign integ_max = VW'(signed'(integ_max_q));
  assign integ_min = VW'(signed'(integ_min_q));

  // controller history
  val_t last_err_q, last_diff_q, integ_q, held_q;

  // working registers
  val_t               e_q, d_q, dd_q, itmp_q, inew_q;
  val_t               pt_q, it_q, dt_q, sa_q, sb_q, y_q, yc_q;
  logic               i_on_q, d_on_q, neg_q;
  logic [63:0]        lo_q, hi_q;
  logic [NW-1:0]      num_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic               out_valid_q;

  // operand selection for the shared multiplier
  logic signed [FIELD_W-1:0] gain;
  val_t                      x;
  logic [FIELD_W-1:0]        g_mag;
  logic [VW-1:0]             x_mag;
  logic [63:0]               x_ext;
  logic [31:0]               mul_b;
  logic [63:0]               product;
  logic                      term_on;

  always_comb begin
    case (cmd_i.term)
      TERM_P: begin
        gain    = prop_gain_q;
        x       = inc ? d_q : e_q;
        term_on = 1'b1;
      end
      TERM_I: begin
        gain    = integ_gain_q;
        x       = inc ? e_q : inew_q;
        term_on = i_on_q;
      end
      TERM_D: begin
        gain    = deriv_gain_q;
        x       = inc ? dd_q : d_q;
        term_on = d_on_q;
      end
      default: begin
        gain    = '0;
        x       = '0;
        term_on = 1'b0;
      end
    endcase
  end

  assign g_mag   = gain[FIELD_W-1] ? (FIELD_W'(0) - unsigned'(gain)) : unsigned'(gain);
  assign x_mag   = x[VW-1] ? (VW'(0) - unsigned'(x)) : unsigned'(x);
  assign x_ext   = 64'(x_mag);
  assign mul_b   = (cmd_i.op == OP_MUL_HI) ? x_ext[63:32] : x_ext[31:0];
  assign product = g_mag * mul_b;

  // product realignment
  logic [95:0] full;
  assign full = {hi_q, 32'd0} + {32'd0, lo_q};

  // error magnitude and gates
  logic [VW-1:0] ae;
  logic          i_on, d_on;
  assign ae   = e_q[VW-1] ? (VW'(0) - unsigned'(e_q)) : unsigned'(e_q);
  assign i_on = (integ_dom_q == '0) || (ae < VW'(integ_dom_q));
  assign d_on = (deriv_dom_q == '0) ||
                (inc ? (ae > VW'(deriv_dom_q)) : (ae < VW'(deriv_dom_q)));

  // constant divider
  logic [NW-1:0] quo;
  logic          div_done;

  dmpc_cdiv #(
    .DIVIDEND_W(NW)
  ) u_cdiv (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (cmd_i.op == OP_DIV_START),
    .sel_thousand_i(cmd_i.term == TERM_I),
    .dividend_i    (num_q),
    .quotient_o    (quo),
    .done_o        (div_done)
  );

  // scaled term with saturation
  logic [NW-1:0] q_raw, lim, q_sat;
  logic [VW-1:0] q_val;
  val_t          term_val;
  always_comb begin
    q_raw = (cmd_i.term == TERM_D) ? num_q : quo;
    lim   = NW'(SatMax[VW-1:0]) + NW'(neg_q);
    q_sat = (q_raw > lim) ? lim : q_raw;
    q_val = q_sat[VW-1:0];
    if (!term_on) begin
      term_val = '0;
    end else if (neg_q) begin
      term_val = val_t'(VW'(0) - q_val);
    end else begin
      term_val = val_t'(q_val);
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        e_q <= sat((VW+1)'(signed'(in_data_i[FIELD_W-1:0])) -
                   (VW+1)'(signed'(in_data_i[2*FIELD_W-1:FIELD_W])));
      end
      OP_DIFF: begin
        d_q    <= sub_sat(e_q, last_err_q);
        itmp_q <= add_sat(integ_q, e_q);
        i_on_q <= i_on;
        d_on_q <= d_on;
      end
      OP_PREP: begin
        dd_q   <= sub_sat(d_q, last_diff_q);
        inew_q <= clamp(itmp_q, integ_max, integ_min);
      end
      OP_MUL_LO: begin
        lo_q  <= product;
        neg_q <= gain[FIELD_W-1] ^ x[VW-1];
      end
      OP_MUL_HI:  hi_q  <= product;
      OP_COMBINE: num_q <= full[PROD_SHIFT +: NW];
      OP_FINISH: begin
        case (cmd_i.term)
          TERM_P:  pt_q <= term_val;
          TERM_I:  it_q <= term_val;
          TERM_D:  dt_q <= term_val;
          default: ;
        endcase
      end
      OP_SUM: begin
        sa_q <= inc ? add_sat(held_q, pt_q) : pt_q;
        sb_q <= add_sat(it_q, dt_q);
      end
      OP_TOTAL:  y_q        <= add_sat(sa_q, sb_q);
      OP_CLAMP:  yc_q       <= clamp(y_q, out_max, out_min);
      OP_COMMIT: out_data_q <= yc_q[OUT_DATA_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q  <= '0;
      last_diff_q <= '0;
      integ_q     <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_COMMIT) begin
        held_q      <= yc_q;
        last_err_q  <= e_q;
        last_diff_q <= d_q;
        if (!inc) begin
          integ_q <= inew_q;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.term_on  = term_on;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/dmpc_ctrl.sv
`timescale 1ns / 1ps
module dmpc_ctrl import dmpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  term_e       term_q, term_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      term_q  <= TERM_P;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    term_d     = term_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.term = term_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = S_PREP;
      end
      S_PREP: begin
        cmd_o.op = OP_PREP;
        term_d   = TERM_P;
        state_d  = S_TERM;
      end
      S_TERM:   state_d = status_i.term_on ? S_MUL_LO : S_FINISH;
      S_MUL_LO: begin
        cmd_o.op = OP_MUL_LO;
        state_d  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.op = OP_MUL_HI;
        state_d  = S_COMBINE;
      end
      S_COMBINE: begin
        cmd_o.op = OP_COMBINE;
        state_d  = (term_q == TERM_D) ? S_FINISH : S_DIV_START;
      end
      S_DIV_START: begin
        cmd_o.op = OP_DIV_START;
        state_d  = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status_i.div_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.op = OP_FINISH;
        case (term_q)
          TERM_P: begin
            term_d  = TERM_I;
            state_d = S_TERM;
          end
          TERM_I: begin
            term_d  = TERM_D;
            state_d = S_TERM;
          end
          default: state_d = S_SUM;
        endcase
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_TOTAL;
      end
      S_TOTAL: begin
        cmd_o.op = OP_TOTAL;
        state_d  = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.op = OP_CLAMP;
        state_d  = S_COMMIT;
      end
      S_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_COMMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/dual_mode_pid_controller.sv
// Dual-form PID controller, signed Q16.16.
// Input stream s_axis_*: one word per sample, setpoint and feedback.
// Output stream m_axis_*: one clamped drive word per accepted sample.
// Config channel cfg_*: register index and 64-bit data, always ready;
//   write only while no sample is in flight.
// Gating: a gated-off I or D term skips its multiplier passes and, for
//   I, the divider. The P and I terms each go through a digit-serial
//   divider by 100 or 1000 that retires 8 quotient bits a cycle; all
//   three products share one 32x32 multiplier, two passes each.
// Throughput: one sample at a time; s_axis_tready is high only when idle,
//   so a new sample is taken only after the last one is committed.
// A finished word sits in the output register while the next sample is
//   taken and worked on; if it is still not taken when the next result is
//   ready, the controller holds that result until m_axis_tready frees it.
// Reset: clears all config registers, the error history, the integral,
//   the held output and the output valid flag.
`timescale 1ns / 1ps
module dual_mode_pid_controller import dmpc_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DMPC_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] setpoint, [63:32] feedback
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // [31:0] drive
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  dmpc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  dmpc_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata)
  );

endmodule

### rtl/dmpc_checker.sv
`timescale 1ns / 1ps
module dmpc_checker import dmpc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while a sample is in flight");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after accept");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write not taken");

endmodule

bind dual_mode_pid_controller dmpc_checker u_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import dmpc_pkg::*;

  localparam int unsigned  LATENCY     = 40;
  localparam int unsigned  NUM_PHASES  = 10;
  localparam int unsigned  PHASE_ITEMS = 75;
  localparam int unsigned  CYCLE_LIMIT = 400000;
  localparam longint       S32_MAX     = 64'sh0000_0000_7FFF_FFFF;
  localparam longint       S32_MIN     = -64'sh0000_0000_8000_0000;
  localparam longint unsigned DIV_P    = 64'd6553600;
  localparam longint unsigned DIV_I    = 64'd65536000;
  localparam longint unsigned DIV_D    = 64'd65536;

  typedef struct {
    bit          is_cfg;
    cfg_reg_e    idx;
    logic [63:0] val;
    logic [31:0] sp;
    logic [31:0] fb;
    bit          typed;
    logic [31:0] drive;
  } stim_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  cfg_reg_e              cfg_addr_i    = REG_CONTROL_MODE;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] setpoint, [63:32] feedback
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [31:0] drive

  dual_mode_pid_controller dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // controller image: settings and history
  mode_e  cur_mode = MODE_INCREMENTAL;
  longint kp = 0, ki = 0, kd = 0, i_dom = 0, d_dom = 0;
  longint out_hi = 0, out_lo = 0, int_hi = 0, int_lo = 0;
  longint last_err = 0, last_diff = 0, integ_acc = 0, held_drive = 0;

  logic [31:0] drive_due [$];
  stim_row_t   plan [$];
  int          mismatches = 0;
  bit          calm = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_gap;
  logic [31:0] rx_want;

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint sat32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint clamp_to(longint v, longint hi, longint lo);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // gain * x / dv, truncated toward zero, saturated
  function automatic longint scale_term(longint g, longint x, longint unsigned dv);
    bit neg;
    longint unsigned mg, mx, q, lim;
    neg = (g < 0) != (x < 0);
    mg  = (g < 0) ? -g : g;
    mx  = (x < 0) ? -x : x;
    q   = (mg * mx) / dv;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (q > lim) q = lim;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic void apply_reg(cfg_reg_e idx, logic [63:0] v);
    case (idx)
      REG_CONTROL_MODE:    cur_mode = mode_e'(v[0]);
      REG_PROP_GAIN:       kp = sx32(v[31:0]);
      REG_INTEG_GAIN:      ki = sx32(v[31:0]);
      REG_DERIV_GAIN:      kd = sx32(v[31:0]);
      REG_INTEG_DOMAIN:    i_dom = longint'({33'b0, v[30:0]});
      REG_DERIV_DOMAIN:    d_dom = longint'({33'b0, v[30:0]});
      REG_OUTPUT_LIMITS:   begin
        out_hi = sx32(v[63:32]);
        out_lo = sx32(v[31:0]);
      end
      REG_INTEGRAL_LIMITS: begin
        int_hi = sx32(v[63:32]);
        int_lo = sx32(v[31:0]);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pid_predict(logic [31:0] sp, logic [31:0] fb);
    longint e, ae, d, dd, pt, it, dt, y;
    bit i_on, d_on;
    e    = sat32(sx32(sp) - sx32(fb));
    ae   = (e < 0) ? -e : e;
    d    = sat32(e - last_err);
    i_on = (i_dom == 0) || (ae < i_dom);
    it   = 0;
    dt   = 0;
    if (cur_mode == MODE_INCREMENTAL) begin
      dd   = sat32(d - last_diff);
      d_on = (d_dom == 0) || (ae > d_dom);
      pt   = scale_term(kp, d, DIV_P);
      if (i_on) it = scale_term(ki, e, DIV_I);
      if (d_on) dt = scale_term(kd, dd, DIV_D);
      y = sat32(sat32(held_drive + pt) + sat32(it + dt));
    end else begin
      d_on      = (d_dom == 0) || (ae < d_dom);
      integ_acc = clamp_to(sat32(integ_acc + e), int_hi, int_lo);
      pt        = scale_term(kp, e, DIV_P);
      if (i_on) it = scale_term(ki, integ_acc, DIV_I);
      if (d_on) dt = scale_term(kd, d, DIV_D);
      y = sat32(pt + sat32(it + dt));
    end
    y          = clamp_to(y, out_hi, out_lo);
    held_drive = y;
    last_err   = e;
    last_diff  = d;
    return y[31:0];
  endfunction

  function automatic int unsigned idle_draw();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic int small_val();
    return int'($urandom_range(0, 1 << 25)) - (1 << 24);
  endfunction

  function automatic logic [31:0] corner_val();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return int'($urandom_range(0, 400 << 16)) - (200 << 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_domain();
    logic [31:0] w;
    case ($urandom_range(0, 4))
      0, 1:    w = '0;
      2:       w = 32'h7FFF_FFFF;
      3:       w = $urandom_range(1, 1 << 24);
      default: w = $urandom;
    endcase
    w[31] = $urandom_range(0, 1);
    return w;
  endfunction

  function automatic logic [63:0] pick_limits();
    int a, b, t;
    a = small_val();
    b = small_val();
    case ($urandom_range(0, 4))
      0, 1: return {32'h7FFF_FFFF, 32'h8000_0000};
      2: begin
        if (a < b) begin
          t = a;
          a = b;
          b = t;
        end
        return {a, b};
      end
      3: return {$urandom, $urandom};
      default: begin
        // minimum above maximum
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        return {a, b};
      end
    endcase
  endfunction

  function automatic stim_row_t sample_row(logic [31:0] sp, logic [31:0] fb,
                                           bit typed = 1'b0, logic [31:0] drive = '0);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = REG_CONTROL_MODE;
    row.val    = '0;
    row.sp     = sp;
    row.fb     = fb;
    row.typed  = typed;
    row.drive  = drive;
    return row;
  endfunction

  function automatic stim_row_t reg_row(cfg_reg_e idx, logic [63:0] val);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    row.sp     = '0;
    row.fb     = '0;
    row.typed  = 1'b0;
    row.drive  = '0;
    return row;
  endfunction

  task automatic send_sample(logic [31:0] sp, logic [31:0] fb, bit typed, logic [31:0] want);
    int unsigned gap;
    logic [31:0] y;
    gap = idle_draw();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {fb, sp};
    do @(posedge clk_i); while (!s_axis_tready);
    y = pid_predict(sp, fb);
    drive_due.push_back(typed ? want : y);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
  endtask

  task automatic drain(int unsigned tail);
    s_axis_tvalid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (drive_due.size() == 0) begin
        $error("drive word %h arrived with nothing expected", m_axis_tdata);
        mismatches++;
      end else begin
        rx_want = drive_due.pop_front();
        if (m_axis_tdata !== rx_want) begin
          $error("drive: expected %h, got %h", rx_want, m_axis_tdata);
          mismatches++;
        end
      end
      rx_gap = idle_draw();
      if (rx_gap != 0) begin
        m_axis_tready <= 1'b0;
        rx_wait       <= rx_gap;
      end
    end else if (!m_axis_tready) begin
      if (rx_wait <= 1) m_axis_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    bit          cfg_open;
    int          sp_base, fb_walk;
    logic [31:0] sp, fb;
    logic [63:0] w_mode, w_kp, w_ki, w_kd, w_idom, w_ddom, w_olim, w_ilim;

    // after reset everything is zero, so the drive is pinned to zero
    plan.push_back(sample_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0));
    plan.push_back(sample_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0));
    plan.push_back(sample_row(32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0));
    plan.push_back(sample_row(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0));
    // equal limits pin the drive
    plan.push_back(reg_row(REG_OUTPUT_LIMITS, {32'h0005_0000, 32'h0005_0000}));
    plan.push_back(sample_row(32'h1234_5678, 32'hFFFF_0000, 1'b1, 32'h0005_0000));
    plan.push_back(sample_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0005_0000));
    // unit gains, incremental form
    plan.push_back(reg_row(REG_OUTPUT_LIMITS, {32'h7FFF_FFFF, 32'h8000_0000}));
    plan.push_back(reg_row(REG_PROP_GAIN, 64'h0000_0000_0064_0000));
    plan.push_back(reg_row(REG_INTEG_GAIN, 64'h0000_0000_03E8_0000));
    plan.push_back(reg_row(REG_DERIV_GAIN, 64'h0000_0000_0001_0000));
    plan.push_back(reg_row(REG_CONTROL_MODE, {63'b0, MODE_INCREMENTAL}));
    plan.push_back(sample_row(32'h0001_0000, 32'h0000_0000));
    plan.push_back(sample_row(32'h0002_0000, 32'h0000_0000));
    plan.push_back(sample_row(32'h0000_0000, 32'h0003_0000));
    plan.push_back(sample_row(32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(sample_row(32'h8000_0000, 32'h7FFF_FFFF));
    // extreme gains, saturating sums
    plan.push_back(reg_row(REG_PROP_GAIN, 64'h0000_0000_7FFF_FFFF));
    plan.push_back(reg_row(REG_INTEG_GAIN, 64'h0000_0000_8000_0000));
    plan.push_back(reg_row(REG_DERIV_GAIN, 64'h0000_0000_7FFF_FFFF));
    plan.push_back(sample_row(32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(sample_row(32'h8000_0000, 32'h7FFF_FFFF));
    // positional form, integral clamped
    plan.push_back(reg_row(REG_CONTROL_MODE, {63'b0, MODE_POSITIONAL}));
    plan.push_back(reg_row(REG_PROP_GAIN, 64'h0000_0000_0064_0000));
    plan.push_back(reg_row(REG_INTEG_GAIN, 64'h0000_0000_03E8_0000));
    plan.push_back(reg_row(REG_DERIV_GAIN, 64'h0000_0000_0001_0000));
    plan.push_back(reg_row(REG_INTEGRAL_LIMITS, {32'h0010_0000, 32'hFFF0_0000}));
    plan.push_back(sample_row(32'h0008_0000, 32'h0000_0000));
    plan.push_back(sample_row(32'h0008_0000, 32'h0000_0000));
    plan.push_back(sample_row(32'h0008_0000, 32'h0000_0000));
    plan.push_back(sample_row(32'h8000_0000, 32'h7FFF_FFFF));
    plan.push_back(sample_row(32'h7FFF_FFFF, 32'h8000_0000));
    // domain gates
    plan.push_back(reg_row(REG_INTEG_DOMAIN, 64'h0000_0000_0001_0000));
    plan.push_back(reg_row(REG_DERIV_DOMAIN, 64'h0000_0000_7FFF_FFFF));
    plan.push_back(sample_row(32'h0000_8000, 32'h0000_0000));
    plan.push_back(sample_row(32'h0002_0000, 32'h0000_0000));
    // minimum above maximum
    plan.push_back(reg_row(REG_OUTPUT_LIMITS, {32'hFFFB_0000, 32'h0005_0000}));
    plan.push_back(sample_row(32'h0010_0000, 32'h0000_0000));
    plan.push_back(sample_row(32'hFFF0_0000, 32'h0000_0000));
    plan.push_back(sample_row(32'h0000_0000, 32'h0000_0000));
    // back to incremental on the shared history
    plan.push_back(reg_row(REG_CONTROL_MODE, {63'b0, MODE_INCREMENTAL}));
    plan.push_back(reg_row(REG_DERIV_DOMAIN, 64'h0000_0000_0001_0000));
    plan.push_back(sample_row(32'h0000_8000, 32'h0000_0000));
    plan.push_back(sample_row(32'h0020_0000, 32'h0000_0000));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    cfg_open = 1'b0;
    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        if (!cfg_open) begin
          drain(LATENCY);
          cfg_open = 1'b1;
        end
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        if (cfg_open) begin
          cfg_valid_i <= 1'b0;
          cfg_open = 1'b0;
        end
        send_sample(plan[k].sp, plan[k].fb, plan[k].typed, plan[k].drive);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain(LATENCY);
      w_mode = {$urandom, $urandom};
      w_kp   = {$urandom, pick_gain()};
      w_ki   = {$urandom, pick_gain()};
      w_kd   = {$urandom, pick_gain()};
      w_idom = {$urandom, pick_domain()};
      w_ddom = {$urandom, pick_domain()};
      w_olim = pick_limits();
      w_ilim = pick_limits();
      if (p == 0) begin
        w_mode = {63'b0, MODE_INCREMENTAL};
        w_kp   = 64'h0000_0000_7FFF_FFFF;
        w_ki   = 64'h0000_0000_7FFF_FFFF;
        w_kd   = 64'h0000_0000_7FFF_FFFF;
        w_idom = 64'h0000_0000_7FFF_FFFF;
        w_ddom = 64'h0000_0000_7FFF_FFFF;
        w_olim = {32'h7FFF_FFFF, 32'h8000_0000};
        w_ilim = {32'h7FFF_FFFF, 32'h8000_0000};
      end else if (p == 1) begin
        w_mode = {63'b0, MODE_POSITIONAL};
        w_kp   = 64'h0000_0000_8000_0000;
        w_ki   = 64'h0000_0000_8000_0000;
        w_kd   = 64'h0000_0000_8000_0000;
        w_idom = '0;
        w_ddom = '0;
        w_olim = {32'h7FFF_FFFF, 32'h8000_0000};
        w_ilim = {32'h7FFF_FFFF, 32'h8000_0000};
      end
      write_reg(REG_CONTROL_MODE, w_mode);
      write_reg(REG_PROP_GAIN, w_kp);
      write_reg(REG_INTEG_GAIN, w_ki);
      write_reg(REG_DERIV_GAIN, w_kd);
      write_reg(REG_INTEG_DOMAIN, w_idom);
      write_reg(REG_DERIV_DOMAIN, w_ddom);
      write_reg(REG_OUTPUT_LIMITS, w_olim);
      write_reg(REG_INTEGRAL_LIMITS, w_ilim);
      cfg_valid_i <= 1'b0;
      calm    = (p % 3 == 2);
      sp_base = small_val();
      fb_walk = small_val();

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            // plant settling towards a mostly steady setpoint
            if ($urandom_range(0, 19) == 0) sp_base = small_val();
            fb_walk = fb_walk + (sp_base - fb_walk) / 4
                      + int'($urandom_range(0, 1 << 18)) - (1 << 17);
            sp = sp_base;
            fb = fb_walk;
          end
          6, 7: begin
            sp = $urandom;
            fb = $urandom;
          end
          8: begin
            sp = corner_val();
            fb = corner_val();
          end
          default: begin
            sp = small_val();
            fb = small_val();
          end
        endcase
        send_sample(sp, fb, 1'b0, '0);
      end
    end

    drain(LATENCY);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/dmpc_pkg.sv
rtl/dmpc_cdiv.sv
rtl/dmpc_datapath.sv
rtl/dmpc_ctrl.sv
rtl/dual_mode_pid_controller.sv
rtl/dmpc_checker.sv
verif/tb.sv
